[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/mspm_pkg.sv]
// ---------------------------------------------------------------------------
// mspm_pkg
// Request/result types, codes and page decode for the slot page mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package mspm_pkg;

    // Request codes
    localparam logic [1:0] REQ_MEM_RD  = 2'd0;
    localparam logic [1:0] REQ_MEM_WR  = 2'd1;
    localparam logic [1:0] REQ_PORT_A  = 2'd2;
    localparam logic [1:0] REQ_MAP_WR  = 2'd3;

    // Backing kinds
    localparam logic [1:0] KIND_ROM    = 2'd0;
    localparam logic [1:0] KIND_RAM    = 2'd1;
    localparam logic [1:0] KIND_CART   = 2'd2;

    // Slot codes
    localparam logic [1:0] SLOT_BASE   = 2'd0;
    localparam logic [1:0] SLOT_EXP    = 2'd3;
    localparam logic [1:0] SUB_ROM     = 2'd0;
    localparam logic [1:0] SUB_RAM     = 2'd2;

    localparam logic [15:0] SEC_ADDR   = 16'hFFFF;
    localparam logic [7:0]  PRIM_RESET = 8'hF0;
    localparam logic [7:0]  SEC_RESET  = 8'hAA;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  wr_data;
        logic [1:0]  mapper_page;
    } req_t;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       handled;
        logic [1:0] page0_kind;
        logic [7:0] page0_bank;
        logic [1:0] page1_kind;
        logic [7:0] page1_bank;
        logic [1:0] page2_kind;
        logic [7:0] page2_bank;
        logic [1:0] page3_kind;
        logic [7:0] page3_bank;
    } res_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] bank;
    } page_map_t;

    // Decode one page from the slot bytes and that page's mapper register
    function automatic page_map_t decode_page(
        input logic [1:0] page,
        input logic [7:0] prim,
        input logic [7:0] sec,
        input logic [7:0] map_bank
    );
        page_map_t  pm;
        logic [1:0] p;
        logic [1:0] s;
        p = prim[{page, 1'b0} +: 2];
        s = sec[{page, 1'b0} +: 2];
        pm.kind = KIND_ROM;
        pm.bank = 8'd0;
        if (p == SLOT_BASE) begin
            case (page)
                2'd0:    begin pm.kind = KIND_ROM; pm.bank = 8'd0; end
                2'd1:    begin pm.kind = KIND_ROM; pm.bank = 8'd1; end
                2'd2:    begin pm.kind = KIND_RAM; pm.bank = 8'd1; end
                default: begin pm.kind = KIND_RAM; pm.bank = 8'd0; end
            endcase
        end else if (p != SLOT_EXP) begin
            pm.kind = KIND_CART;
        end else if (s == SUB_RAM) begin
            pm.kind = KIND_RAM;
            pm.bank = map_bank;
        end else if (s == SUB_ROM) begin
            // odd pages take bank 3, even pages bank 2
            pm.bank = {6'd0, 1'b1, page[0]};
        end
        return pm;
    endfunction

endpackage

`default_nettype wire

[design/memory_slot_page_mapper_core.sv]
// ---------------------------------------------------------------------------
// memory_slot_page_mapper_core
// Slot and RAM mapper decode for four 16 KiB CPU pages.
// ---------------------------------------------------------------------------
// Usage:
//   One request in on req (req_valid/req_stall), one result out on res
//   (res_valid/res_stall) for every request, in order. A request is taken
//   at a rising edge with req_valid high and req_stall low.
//   The request updates the slot bytes and mapper registers at acceptance;
//   its result carries the read data, the handled flag and the decode of
//   all four pages as it stands after that update.
//   The result is registered, into the skid entry if the result register
//   is held. Throughput: one request per cycle while req_stall is low; the
//   whole decode sits between the request edge and the result register.
//   A two-entry output (result register plus skid register) absorbs a
//   receiver stall: req_stall rises, from a register, once the skid entry
//   is occupied, so the request side never waits on res_stall directly.
//   Reset: primary slots 0xF0, secondary slots 0xAA, mapper registers
//   3, 2, 1, 0 for pages 0..3; no result pending.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module memory_slot_page_mapper_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire mspm_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_stall,
    output mspm_pkg::res_t      res
);
    import mspm_pkg::*;

    logic [7:0] prim_reg;
    logic [7:0] prim_next;
    logic [7:0] sec_reg;
    logic [7:0] sec_next;
    logic [7:0] map_reg  [4];
    logic [7:0] map_next [4];

    res_t       out_reg;
    logic       out_valid_reg;
    res_t       skid_reg;
    logic       skid_valid_reg;

    logic       accept;
    logic       out_take;
    logic       sec_hit;
    res_t       res_next;
    page_map_t  pm [4];

    assign accept   = req_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !res_stall;
    assign sec_hit  = (req.addr == SEC_ADDR) && (prim_reg[7:6] == SLOT_EXP);

    // State update and result for the incoming request
    always_comb
    begin
        prim_next = prim_reg;
        sec_next  = sec_reg;
        for (int i = 0; i < 4; i++)
        begin
            map_next[i] = map_reg[i];
        end
        res_next.rd_data = 8'd0;
        res_next.handled = 1'b0;
        case (req.req_type)
            REQ_MEM_RD:
            begin
                if (sec_hit)
                begin
                    res_next.rd_data = ~sec_reg;
                    res_next.handled = 1'b1;
                end
            end
            REQ_MEM_WR:
            begin
                if (sec_hit)
                begin
                    sec_next         = req.wr_data;
                    res_next.handled = 1'b1;
                end
            end
            REQ_PORT_A:
            begin
                prim_next        = req.wr_data;
                res_next.handled = 1'b1;
            end
            REQ_MAP_WR:
            begin
                map_next[req.mapper_page] = req.wr_data;
                res_next.handled          = 1'b1;
            end
            default:
            begin
                res_next.handled = 1'b0;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            pm[i] = decode_page(2'(i), prim_next, sec_next, map_next[i]);
        end
        res_next.page0_kind = pm[0].kind;
        res_next.page0_bank = pm[0].bank;
        res_next.page1_kind = pm[1].kind;
        res_next.page1_bank = pm[1].bank;
        res_next.page2_kind = pm[2].kind;
        res_next.page2_bank = pm[2].bank;
        res_next.page3_kind = pm[3].kind;
        res_next.page3_bank = pm[3].bank;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg   <= PRIM_RESET;
            sec_reg    <= SEC_RESET;
            map_reg[0] <= 8'd3;
            map_reg[1] <= 8'd2;
            map_reg[2] <= 8'd1;
            map_reg[3] <= 8'd0;
        end
        else if (accept)
        begin
            prim_reg <= prim_next;
            sec_reg  <= sec_next;
            for (int i = 0; i < 4; i++)
            begin
                map_reg[i] <= map_next[i];
            end
        end
    end

    // Result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign req_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_port_a_loads, clk, rst_n,
                 accept && (req.req_type == REQ_PORT_A),
                 prim_reg == $past(req.wr_data))
    `ASSERT_IMPLIES(a_writes_handled, clk, rst_n,
                    accept && ((req.req_type == REQ_PORT_A) ||
                               (req.req_type == REQ_MAP_WR)),
                    res_next.handled && (res_next.rd_data == 8'd0))
    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)

endmodule

`default_nettype wire
